/* design/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg: shared definitions for the line segment clipper
// Widths, register indexes, outcode bits, state types and the request and
// response structs that pass between the sequencer and the interpolation unit.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // Coordinate width of the endpoint fields.
  localparam int COORD_BITS = 16;
  // Width of the view size registers.
  localparam int CFG_BITS = 16;
  // Width of the configuration register index.
  localparam int CFG_ADDR_BITS = 8;

  // Working coordinate width: holds a coordinate or a clip limit with margin.
  localparam int WORK_BITS = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
  // Width of a coordinate difference.
  localparam int DIFF_BITS = WORK_BITS + 1;
  // Width of the product of two differences.
  localparam int PROD_BITS = 2 * DIFF_BITS;
  // Divider iteration counter, able to hold PROD_BITS.
  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  // Upper bound on clip steps for one segment.
  localparam int MAX_CLIPS = 8;
  localparam int STEP_BITS = $clog2(MAX_CLIPS + 1);

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_BITS-1:0] REG_VIEW_WIDTH  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_VIEW_HEIGHT = CFG_ADDR_BITS'(1);
  localparam logic [CFG_BITS-1:0]      VIEW_RESET      = CFG_BITS'(1024);

  // Outcode bits.
  localparam logic [3:0] CODE_XMIN = 4'd1;
  localparam logic [3:0] CODE_YMIN = 4'd2;
  localparam logic [3:0] CODE_XMAX = 4'd4;
  localparam logic [3:0] CODE_YMAX = 4'd8;

  typedef enum logic [1:0] {
    EDGE_XMIN,
    EDGE_XMAX,
    EDGE_YMIN,
    EDGE_YMAX
  } clip_edge_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_PREP,
    U_DIV,
    U_FIN
  } unit_state_t;

  // Request to the interpolation unit: base + slope * span / run.
  typedef struct packed {
    logic                 start;
    logic [WORK_BITS-1:0] base;
    logic [DIFF_BITS-1:0] slope;
    logic [DIFF_BITS-1:0] span;
    logic [DIFF_BITS-1:0] run;
  } interp_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORK_BITS-1:0] value;
  } interp_resp_t;

endpackage

/* design/lsc_if.sv */
// ----------------------------------------------------------------------------
// lsc_if: channel interfaces of the line segment clipper
// Segment input, clip result and configuration write channels, each with a
// valid/ready handshake and source and sink modports.
// ----------------------------------------------------------------------------
interface lsc_in_if;
  logic                            valid;
  logic                            ready;
  logic [lsc_pkg::COORD_BITS-1:0]  start_x;
  logic [lsc_pkg::COORD_BITS-1:0]  start_y;
  logic [lsc_pkg::COORD_BITS-1:0]  end_x;
  logic [lsc_pkg::COORD_BITS-1:0]  end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_out_if;
  logic                            valid;
  logic                            ready;
  logic [lsc_pkg::COORD_BITS-1:0]  clip_start_x;
  logic [lsc_pkg::COORD_BITS-1:0]  clip_start_y;
  logic [lsc_pkg::COORD_BITS-1:0]  clip_end_x;
  logic [lsc_pkg::COORD_BITS-1:0]  clip_end_y;
  logic                            invisible;

  modport source (output valid, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                  invisible, input ready);
  modport sink   (input valid, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                  invisible, output ready);
endinterface

interface lsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lsc_pkg::CFG_ADDR_BITS-1:0] addr;
  logic [lsc_pkg::CFG_BITS-1:0]      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* design/line_segment_clipper.sv */
// ----------------------------------------------------------------------------
// line_segment_clipper: Cohen-Sutherland line clipper
// Clips a signed integer segment to the rectangle (0,0)..(width-1,height-1),
// moving an outside endpoint onto one violated edge at a time.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ---------------------------------------------------------
//  in_ch    sink       start_x, start_y, end_x, end_y (signed endpoints)
//  out_ch   source     clip_start_x/y, clip_end_x/y, invisible
//  cfg_ch   sink       addr (0 = view width, 1 = view height), data
//
//  A new input beat is accepted only when the sequencer is idle, once the
//  previous segment has been clipped and its result loaded. Each edge clip
//  costs one outcode check plus one pass through the shared interpolation
//  unit: a multiply step, a setup step, a radix-2 divide and a finishing
//  step. Reset is synchronous and active low; both view registers return
//  to 1024. A finished result waits in the output register while the next
//  input beat is taken; the sequencer stalls only if it finishes again
//  before that result has been taken.
//  The configuration port is always ready and ignores unknown indexes.
//
module line_segment_clipper (
  input  logic            clk,
  input  logic            rst_n,
  lsc_in_if.sink          in_ch,
  lsc_out_if.source       out_ch,
  lsc_cfg_if.sink         cfg_ch
);

  localparam int CB = lsc_pkg::COORD_BITS;
  localparam int WB = lsc_pkg::WORK_BITS;
  localparam int DB = lsc_pkg::DIFF_BITS;
  localparam int SB = lsc_pkg::STEP_BITS;

  // Outcode of a point against the current rectangle. The x and y bits are
  // each "below zero" first, then "above limit".
  function automatic logic [3:0] outcode(input logic signed [WB-1:0] px,
                                         input logic signed [WB-1:0] py,
                                         input logic signed [WB-1:0] lim_x,
                                         input logic signed [WB-1:0] lim_y);
    logic [3:0] c;
    c = 4'd0;
    if (px < 0) begin
      c = lsc_pkg::CODE_XMIN;
    end else if (px > lim_x) begin
      c = lsc_pkg::CODE_XMAX;
    end
    if (py < 0) begin
      c = c | lsc_pkg::CODE_YMIN;
    end else if (py > lim_y) begin
      c = c | lsc_pkg::CODE_YMAX;
    end
    return c;
  endfunction

  // Control state.
  lsc_pkg::seq_state_t   state_r, state_nxt;
  logic [SB-1:0]         steps_r, steps_nxt;
  logic                  pick_end_r, pick_end_nxt;
  lsc_pkg::clip_edge_t   edge_r, edge_nxt;
  logic                  hide_r, hide_nxt;
  logic [lsc_pkg::CFG_BITS-1:0] width_r, width_nxt;
  logic [lsc_pkg::CFG_BITS-1:0] height_r, height_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working endpoints and the original input beat.
  logic [WB-1:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic [WB-1:0] x2_r, x2_nxt, y2_r, y2_nxt;
  logic [CB-1:0] ox1_r, ox1_nxt, oy1_r, oy1_nxt;
  logic [CB-1:0] ox2_r, ox2_nxt, oy2_r, oy2_nxt;

  // Output register.
  logic [CB-1:0] res_x1_r, res_x1_nxt, res_y1_r, res_y1_nxt;
  logic [CB-1:0] res_x2_r, res_x2_nxt, res_y2_r, res_y2_nxt;
  logic          res_inv_r, res_inv_nxt;

  logic signed [WB-1:0] xmax, ymax;
  logic signed [WB-1:0] x1_s, y1_s, x2_s, y2_s;
  logic [3:0]           code1, code2, code_sel;
  logic signed [DB-1:0] dx, dy;
  logic [WB-1:0]        new_x, new_y;
  lsc_pkg::clip_edge_t  edge_sel;
  logic                 out_load;

  lsc_pkg::interp_req_t  ireq;
  lsc_pkg::interp_resp_t iresp;

  lsc_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .resp  (iresp)
  );

  // Limits are width-1 and height-1; a zero size gives -1 and an empty view.
  assign xmax = $signed(WB'(width_r) - WB'(1));
  assign ymax = $signed(WB'(height_r) - WB'(1));

  assign x1_s = $signed(x1_r);
  assign y1_s = $signed(y1_r);
  assign x2_s = $signed(x2_r);
  assign y2_s = $signed(y2_r);

  assign code1    = outcode(x1_s, y1_s, xmax, ymax);
  assign code2    = outcode(x2_s, y2_s, xmax, ymax);
  assign code_sel = (code1 != 4'd0) ? code1 : code2;

  assign dx = DB'(x2_s) - DB'(x1_s);
  assign dy = DB'(y2_s) - DB'(y1_s);

  // The first violated edge in the order xmin, xmax, ymin, ymax.
  always_comb begin
    priority if ((code_sel & lsc_pkg::CODE_XMIN) != 4'd0) begin
      edge_sel = lsc_pkg::EDGE_XMIN;
    end else if ((code_sel & lsc_pkg::CODE_XMAX) != 4'd0) begin
      edge_sel = lsc_pkg::EDGE_XMAX;
    end else if ((code_sel & lsc_pkg::CODE_YMIN) != 4'd0) begin
      edge_sel = lsc_pkg::EDGE_YMIN;
    end else begin
      edge_sel = lsc_pkg::EDGE_YMAX;
    end
  end

  // Interpolation operands. The base is always the first endpoint and the
  // slope and run are always second minus first, whichever endpoint moves.
  always_comb begin
    ireq.start = 1'b0;
    unique case (edge_sel)
      lsc_pkg::EDGE_XMIN: begin
        ireq.base  = y1_r;
        ireq.slope = dy;
        ireq.span  = DB'(0) - DB'(x1_s);
        ireq.run   = dx;
      end
      lsc_pkg::EDGE_XMAX: begin
        ireq.base  = y1_r;
        ireq.slope = dy;
        ireq.span  = DB'(xmax) - DB'(x1_s);
        ireq.run   = dx;
      end
      lsc_pkg::EDGE_YMIN: begin
        ireq.base  = x1_r;
        ireq.slope = dx;
        ireq.span  = DB'(0) - DB'(y1_s);
        ireq.run   = dy;
      end
      lsc_pkg::EDGE_YMAX: begin
        ireq.base  = x1_r;
        ireq.slope = dx;
        ireq.span  = DB'(ymax) - DB'(y1_s);
        ireq.run   = dy;
      end
    endcase
    if (state_r == lsc_pkg::ST_CHECK && (code1 | code2) != 4'd0 &&
        (code1 & code2) == 4'd0 && steps_r < SB'(lsc_pkg::MAX_CLIPS)) begin
      ireq.start = 1'b1;
    end
  end

  // The new point sits on the chosen edge; the other coordinate comes from
  // the interpolation unit.
  always_comb begin
    unique case (edge_r)
      lsc_pkg::EDGE_XMIN: begin
        new_x = WB'(0);
        new_y = iresp.value;
      end
      lsc_pkg::EDGE_XMAX: begin
        new_x = xmax;
        new_y = iresp.value;
      end
      lsc_pkg::EDGE_YMIN: begin
        new_x = iresp.value;
        new_y = WB'(0);
      end
      lsc_pkg::EDGE_YMAX: begin
        new_x = iresp.value;
        new_y = ymax;
      end
    endcase
  end

  assign in_ch.ready  = (state_r == lsc_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.clip_start_x = res_x1_r;
  assign out_ch.clip_start_y = res_y1_r;
  assign out_ch.clip_end_x   = res_x2_r;
  assign out_ch.clip_end_y   = res_y2_r;
  assign out_ch.invisible    = res_inv_r;

  // The result register loads when the sequencer is done and the register is
  // empty or being emptied in this cycle.
  assign out_load = (state_r == lsc_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsc_pkg::ST_IDLE;
      steps_r     <= '0;
      pick_end_r  <= 1'b0;
      edge_r      <= lsc_pkg::EDGE_XMIN;
      hide_r      <= 1'b0;
      width_r     <= lsc_pkg::VIEW_RESET;
      height_r    <= lsc_pkg::VIEW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      steps_r     <= steps_nxt;
      pick_end_r  <= pick_end_nxt;
      edge_r      <= edge_nxt;
      hide_r      <= hide_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    x2_r      <= x2_nxt;
    y2_r      <= y2_nxt;
    ox1_r     <= ox1_nxt;
    oy1_r     <= oy1_nxt;
    ox2_r     <= ox2_nxt;
    oy2_r     <= oy2_nxt;
    res_x1_r  <= res_x1_nxt;
    res_y1_r  <= res_y1_nxt;
    res_x2_r  <= res_x2_nxt;
    res_y2_r  <= res_y2_nxt;
    res_inv_r <= res_inv_nxt;
  end

  // Sequencer: take a beat, then alternate outcode checks and clip steps on
  // the shared unit until the segment is accepted or rejected.
  always_comb begin
    state_nxt    = state_r;
    steps_nxt    = steps_r;
    pick_end_nxt = pick_end_r;
    edge_nxt     = edge_r;
    hide_nxt     = hide_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    x1_nxt       = x1_r;
    y1_nxt       = y1_r;
    x2_nxt       = x2_r;
    y2_nxt       = y2_r;
    ox1_nxt      = ox1_r;
    oy1_nxt      = oy1_r;
    ox2_nxt      = ox2_r;
    oy2_nxt      = oy2_r;
    res_x1_nxt   = res_x1_r;
    res_y1_nxt   = res_y1_r;
    res_x2_nxt   = res_x2_r;
    res_y2_nxt   = res_y2_r;
    res_inv_nxt  = res_inv_r;

    if (cfg_ch.valid) begin
      if (cfg_ch.addr == lsc_pkg::REG_VIEW_WIDTH) begin
        width_nxt = cfg_ch.data;
      end
      if (cfg_ch.addr == lsc_pkg::REG_VIEW_HEIGHT) begin
        height_nxt = cfg_ch.data;
      end
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      lsc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          x1_nxt    = WB'($signed(in_ch.start_x));
          y1_nxt    = WB'($signed(in_ch.start_y));
          x2_nxt    = WB'($signed(in_ch.end_x));
          y2_nxt    = WB'($signed(in_ch.end_y));
          ox1_nxt   = in_ch.start_x;
          oy1_nxt   = in_ch.start_y;
          ox2_nxt   = in_ch.end_x;
          oy2_nxt   = in_ch.end_y;
          steps_nxt = '0;
          state_nxt = lsc_pkg::ST_CHECK;
        end
      end
      lsc_pkg::ST_CHECK: begin
        priority if ((code1 | code2) == 4'd0) begin
          hide_nxt  = 1'b0;
          state_nxt = lsc_pkg::ST_DONE;
        end else if ((code1 & code2) != 4'd0 ||
                     steps_r >= SB'(lsc_pkg::MAX_CLIPS)) begin
          hide_nxt  = 1'b1;
          state_nxt = lsc_pkg::ST_DONE;
        end else begin
          steps_nxt    = steps_r + SB'(1);
          pick_end_nxt = (code1 == 4'd0);
          edge_nxt     = edge_sel;
          state_nxt    = lsc_pkg::ST_WAIT;
        end
      end
      lsc_pkg::ST_WAIT: begin
        if (iresp.done) begin
          if (pick_end_r) begin
            x2_nxt = new_x;
            y2_nxt = new_y;
          end else begin
            x1_nxt = new_x;
            y1_nxt = new_y;
          end
          state_nxt = lsc_pkg::ST_CHECK;
        end
      end
      lsc_pkg::ST_DONE: begin
        if (out_load) begin
          res_x1_nxt    = hide_r ? ox1_r : x1_r[CB-1:0];
          res_y1_nxt    = hide_r ? oy1_r : y1_r[CB-1:0];
          res_x2_nxt    = hide_r ? ox2_r : x2_r[CB-1:0];
          res_y2_nxt    = hide_r ? oy2_r : y2_r[CB-1:0];
          res_inv_nxt   = hide_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lsc_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

/* design/lsc_interp.sv */
// ----------------------------------------------------------------------------
// lsc_interp: shared interpolation unit
// Computes base + slope * span / run with the quotient truncated toward zero:
// a multiply step, a sign setup step, then a radix-2 restoring divide
// on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsc_interp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsc_pkg::interp_req_t  req,
  output lsc_pkg::interp_resp_t resp
);

  localparam int WB = lsc_pkg::WORK_BITS;
  localparam int DB = lsc_pkg::DIFF_BITS;
  localparam int PB = lsc_pkg::PROD_BITS;
  localparam int CB = lsc_pkg::CNT_BITS;

  lsc_pkg::unit_state_t state_r, state_nxt;

  logic [WB-1:0] base_r, base_nxt;
  logic [DB-1:0] slope_r, slope_nxt;
  logic [DB-1:0] span_r, span_nxt;
  logic [DB-1:0] run_r, run_nxt;
  logic [PB-1:0] prod_r, prod_nxt;
  logic [DB-1:0] den_r, den_nxt;
  logic [DB-1:0] rem_r, rem_nxt;
  logic [PB-1:0] quo_r, quo_nxt;
  logic          neg_r, neg_nxt;
  logic          zero_r, zero_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;

  logic signed [PB-1:0] prod_w;
  logic signed [DB-1:0] slope_s, span_s;
  logic [DB:0]          rem_sh;
  logic [DB:0]          trial;
  logic                 fits;
  logic [WB-1:0]        q_low;
  logic [WB-1:0]        q_signed;

  assign slope_s = $signed(slope_r);
  assign span_s  = $signed(span_r);
  assign prod_w  = slope_s * span_s;

  assign rem_sh   = {rem_r, quo_r[PB-1]};
  assign trial    = rem_sh - {1'b0, den_r};
  assign fits     = ~trial[DB];
  assign q_low    = quo_r[WB-1:0];
  assign q_signed = neg_r ? (WB'(0) - q_low) : q_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsc_pkg::U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    slope_r <= slope_nxt;
    span_r  <= span_nxt;
    run_r   <= run_nxt;
    prod_r  <= prod_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    zero_r  <= zero_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    slope_nxt  = slope_r;
    span_nxt   = span_r;
    run_nxt    = run_r;
    prod_nxt   = prod_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    cnt_nxt    = cnt_r;
    resp.done  = 1'b0;
    resp.value = base_r;

    unique case (state_r)
      lsc_pkg::U_IDLE: begin
        if (req.start) begin
          base_nxt  = req.base;
          slope_nxt = req.slope;
          span_nxt  = req.span;
          run_nxt   = req.run;
          state_nxt = lsc_pkg::U_MUL;
        end
      end
      lsc_pkg::U_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = lsc_pkg::U_PREP;
      end
      lsc_pkg::U_PREP: begin
        // Divide magnitudes; the sign is applied to the quotient afterward,
        // which gives truncation toward zero.
        quo_nxt   = prod_r[PB-1] ? (PB'(0) - prod_r) : prod_r;
        den_nxt   = run_r[DB-1] ? (DB'(0) - run_r) : run_r;
        neg_nxt   = prod_r[PB-1] ^ run_r[DB-1];
        zero_nxt  = (run_r == DB'(0));
        rem_nxt   = DB'(0);
        cnt_nxt   = CB'(PB);
        state_nxt = lsc_pkg::U_DIV;
      end
      lsc_pkg::U_DIV: begin
        rem_nxt = fits ? trial[DB-1:0] : rem_sh[DB-1:0];
        quo_nxt = {quo_r[PB-2:0], fits};
        cnt_nxt = cnt_r - CB'(1);
        if (cnt_r == CB'(1)) begin
          state_nxt = lsc_pkg::U_FIN;
        end
      end
      lsc_pkg::U_FIN: begin
        // The result lies between the endpoints, so the low bits suffice.
        resp.done  = 1'b1;
        resp.value = zero_r ? base_r : (base_r + q_signed);
        state_nxt  = lsc_pkg::U_IDLE;
      end
    endcase
  end

endmodule
